/* hw/rtl/hti_pkg.sv */
// Package for the heightfield triangle interpolator.
// Holds field widths, request action codes and configuration register indexes.
// No dependencies.
package hti_pkg;

  localparam int COORD_W  = 32;
  localparam int HEIGHT_W = 24;
  localparam int VIDX_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CELLS_W  = 5;
  localparam int PRODUCT_POINT = 40;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 3'd4;

endpackage

/* hw/rtl/hti_if.sv */
// Channel interfaces for the heightfield triangle interpolator.
// Request, result and configuration channels; depend on hti_pkg.
interface hti_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [hti_pkg::VIDX_W-1:0]           vertex_col;
  logic [hti_pkg::VIDX_W-1:0]           vertex_row;
  logic signed [hti_pkg::HEIGHT_W-1:0]  height_value;
  logic signed [hti_pkg::COORD_W-1:0]   query_x;
  logic signed [hti_pkg::COORD_W-1:0]   query_z;
  modport source (output valid, action, vertex_col, vertex_row, height_value, query_x,
                  query_z, input ready);
  modport sink (input valid, action, vertex_col, vertex_row, height_value, query_x,
                query_z, output ready);
endinterface

interface hti_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hti_pkg::HEIGHT_W-1:0]  height;
  logic                                 clamped;
  modport source (output valid, height, clamped, input ready);
  modport sink (input valid, height, clamped, output ready);
endinterface

interface hti_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [hti_pkg::CFG_IDX_W-1:0]        index;
  logic [hti_pkg::COORD_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/hti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hti_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/heightfield_triangle_interpolator.sv */
// Heightfield triangle interpolator: vertex height grid with point queries.
// One request per cycle sustained while the result side is ready; out_if.ready low stalls the pipeline.
// Rate is set by the 8-stage pipeline with three replicated grid RAMs (one read each).
// Write requests update the grid in stage 4 and give no result.
// Reset (rst_n, synchronous) clears valid bits and returns config to its defaults; the grid is not cleared.
// Depends on hti_pkg, hti_if.sv and hti_ram.
module heightfield_triangle_interpolator #(
  parameter int MAX_CELLS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  hti_in_if.sink    in_if,
  hti_out_if.source out_if,
  hti_cfg_if.sink   cfg_if
);
  import hti_pkg::*;

  localparam int GS = MAX_CELLS + 1;
  localparam int DEPTH = GS * GS;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(GS);
  localparam int FB = FRACTION_BITS;
  localparam int PW = 26 + FB;
  localparam int SW = 28 + FB;
  localparam logic signed [SW-1:0] HALF = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [SW-1:0] HMAX = {{(SW-24){1'b0}}, 24'h7FFFFF};
  localparam logic signed [SW-1:0] HMIN = {{(SW-24){1'b1}}, 24'h800000};

  // configuration
  logic [COORD_W-1:0] origin_r [2];
  logic [COORD_W-1:0] scale_r [2];
  logic [CELLS_W-1:0] cell_count_r;
  logic [IW-1:0]      n_eff;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]  <= '0;
      origin_r[1]  <= '0;
      scale_r[0]   <= 32'd167772;
      scale_r[1]   <= 32'd167772;
      cell_count_r <= 5'd16;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ORIGIN_X:   origin_r[0]  <= cfg_if.data;
        CFG_ORIGIN_Z:   origin_r[1]  <= cfg_if.data;
        CFG_SCALE_X:    scale_r[0]   <= cfg_if.data;
        CFG_SCALE_Z:    scale_r[1]   <= cfg_if.data;
        CFG_CELL_COUNT: cell_count_r <= cfg_if.data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cell_count_r == '0) begin
      n_eff = IW'(1);
    end else if (32'(cell_count_r) > MAX_CELLS) begin
      n_eff = IW'(MAX_CELLS);
    end else begin
      n_eff = IW'(cell_count_r);
    end
  end

  // stage enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_v_r;
  logic en1, en2, en3, en4, en5, en6, en7, en_out;

  assign en_out = !out_v_r || out_if.ready;
  assign en7 = !v7_r || en_out;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_if.ready = en1;

  // write request side fields travel through stages 1 to 4
  logic                act1_r, act2_r, act3_r, act4_r;
  logic                wok1_r, wok2_r, wok3_r, wok4_r;
  logic [VIDX_W-1:0]   col1_r, col2_r, col3_r, col4_r;
  logic [VIDX_W-1:0]   row1_r, row2_r, row3_r, row4_r;
  logic [HEIGHT_W-1:0] hv1_r, hv2_r, hv3_r, hv4_r;
  logic                wok_nxt;

  assign wok_nxt = (32'(in_if.vertex_col) <= MAX_CELLS) && (32'(in_if.vertex_row) <= MAX_CELLS);

  // stage 1: offset magnitude
  logic signed [COORD_W:0] d_nxt [2];
  logic [COORD_W:0]        mag_nxt [2];
  logic [COORD_W:0]        mag1_r [2];
  logic                    neg1_r [2];

  always_comb begin
    d_nxt[0] = $signed({in_if.query_x[COORD_W-1], in_if.query_x})
             - $signed({origin_r[0][COORD_W-1], origin_r[0]});
    d_nxt[1] = $signed({in_if.query_z[COORD_W-1], in_if.query_z})
             - $signed({origin_r[1][COORD_W-1], origin_r[1]});
    for (int k = 0; k < 2; k++) begin
      mag_nxt[k] = d_nxt[k][COORD_W] ? (~d_nxt[k] + 1'b1) : d_nxt[k];
    end
  end

  // stage 2: low 32x32 product
  logic [2*COORD_W-1:0] lo2_r [2];
  logic                 hi2_r [2];
  logic                 neg2_r [2];

  // stage 3: index and fraction
  logic [2*COORD_W-1:0] lo3_r [2];
  logic                 hi3_r [2];
  logic                 neg3_r [2];
  logic [2*COORD_W:0]   prod [2];
  logic [24:0]          ip [2];
  logic [IW-1:0]        idx_nxt [2];
  logic [FB-1:0]        fr_nxt [2];
  logic                 cl_nxt [2];
  logic [IW-1:0]        idx4_r [2];
  logic [FB-1:0]        fr4_r [2];
  logic                 cl4_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod[k] = {1'b0, lo3_r[k]} + (hi3_r[k] ? {1'b0, scale_r[k], 32'b0} : '0);
      ip[k] = prod[k][2*COORD_W:PRODUCT_POINT];
      fr_nxt[k] = prod[k][PRODUCT_POINT-1 -: FB];
      if (neg3_r[k] && prod[k] != '0) begin
        idx_nxt[k] = '0;
        fr_nxt[k]  = '0;
        cl_nxt[k]  = 1'b1;
      end else if (ip[k] > 25'(n_eff)) begin
        idx_nxt[k] = n_eff;
        cl_nxt[k]  = 1'b1;
      end else begin
        idx_nxt[k] = IW'(ip[k]);
        cl_nxt[k]  = 1'b0;
      end
    end
  end

  // stage 4: grid addresses, writes and reads
  logic [IW-1:0] nx, nz;
  logic          upper;
  logic [AW-1:0] a1, a3, am, waddr;
  logic          we;

  assign nx = (idx4_r[0] == n_eff) ? n_eff : idx4_r[0] + 1'b1;
  assign nz = (idx4_r[1] == n_eff) ? n_eff : idx4_r[1] + 1'b1;
  assign upper = fr4_r[1] > fr4_r[0];
  assign a1 = AW'(idx4_r[1]) * AW'(GS) + AW'(idx4_r[0]);
  assign a3 = AW'(nz) * AW'(GS) + AW'(nx);
  assign am = upper ? AW'(nz) * AW'(GS) + AW'(idx4_r[0])
                    : AW'(idx4_r[1]) * AW'(GS) + AW'(nx);
  assign waddr = AW'(row4_r) * AW'(GS) + AW'(col4_r);
  assign we = v4_r && en5 && (act4_r == ACT_WRITE) && wok4_r;

  logic [HEIGHT_W-1:0] h1_rd, h3_rd, hm_rd;

  hti_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram1 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(hv4_r), .re(en5), .raddr(a1), .rdata(h1_rd)
  );
  hti_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ram3 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(hv4_r), .re(en5), .raddr(a3), .rdata(h3_rd)
  );
  hti_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_ramm (
    .clk(clk), .we(we), .waddr(waddr), .wdata(hv4_r), .re(en5), .raddr(am), .rdata(hm_rd)
  );

  // stage 5: grid data present, edge differences
  logic [FB-1:0]        fx5_r, fz5_r;
  logic                 up5_r, cl5_r;
  logic signed [24:0]   h1e, h3e, hme, da_nxt, db_nxt;

  assign h1e = $signed({h1_rd[HEIGHT_W-1], h1_rd});
  assign h3e = $signed({h3_rd[HEIGHT_W-1], h3_rd});
  assign hme = $signed({hm_rd[HEIGHT_W-1], hm_rd});
  assign da_nxt = up5_r ? hme - h1e : h3e - hme;
  assign db_nxt = up5_r ? h3e - hme : hme - h1e;

  // stage 6: products
  logic signed [24:0]          da6_r, db6_r;
  logic signed [HEIGHT_W-1:0]  h16_r;
  logic [FB-1:0]               fx6_r, fz6_r;
  logic                        cl6_r;
  logic signed [PW-1:0]        p1_nxt, p2_nxt;

  assign p1_nxt = da6_r * $signed({1'b0, fz6_r});
  assign p2_nxt = db6_r * $signed({1'b0, fx6_r});

  // stage 7: sum, round, saturate
  logic signed [PW-1:0]        p17_r, p27_r;
  logic signed [HEIGHT_W-1:0]  h17_r;
  logic                        cl7_r;
  logic signed [SW-1:0]        sum, res;
  logic [HEIGHT_W-1:0]         height_nxt;

  always_comb begin
    sum = $signed({{4{h17_r[HEIGHT_W-1]}}, h17_r, {FB{1'b0}}})
        + $signed({{2{p17_r[PW-1]}}, p17_r})
        + $signed({{2{p27_r[PW-1]}}, p27_r})
        + HALF;
    res = sum >>> FB;
    if (res > HMAX) begin
      height_nxt = 24'h7FFFFF;
    end else if (res < HMIN) begin
      height_nxt = 24'h800000;
    end else begin
      height_nxt = res[HEIGHT_W-1:0];
    end
  end

  logic [HEIGHT_W-1:0] out_h_r;
  logic                out_cl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_if.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r && (act4_r == ACT_QUERY);
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en_out) out_v_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      act1_r <= in_if.action;
      wok1_r <= wok_nxt;
      col1_r <= in_if.vertex_col;
      row1_r <= in_if.vertex_row;
      hv1_r  <= in_if.height_value;
      for (int k = 0; k < 2; k++) begin
        mag1_r[k] <= mag_nxt[k];
        neg1_r[k] <= d_nxt[k][COORD_W];
      end
    end
    if (en2) begin
      act2_r <= act1_r; wok2_r <= wok1_r; col2_r <= col1_r; row2_r <= row1_r; hv2_r <= hv1_r;
      for (int k = 0; k < 2; k++) begin
        lo2_r[k]  <= mag1_r[k][COORD_W-1:0] * scale_r[k];
        hi2_r[k]  <= mag1_r[k][COORD_W];
        neg2_r[k] <= neg1_r[k];
      end
    end
    if (en3) begin
      act3_r <= act2_r; wok3_r <= wok2_r; col3_r <= col2_r; row3_r <= row2_r; hv3_r <= hv2_r;
      for (int k = 0; k < 2; k++) begin
        lo3_r[k]  <= lo2_r[k];
        hi3_r[k]  <= hi2_r[k];
        neg3_r[k] <= neg2_r[k];
      end
    end
    if (en4) begin
      act4_r <= act3_r; wok4_r <= wok3_r; col4_r <= col3_r; row4_r <= row3_r; hv4_r <= hv3_r;
      for (int k = 0; k < 2; k++) begin
        idx4_r[k] <= idx_nxt[k];
        fr4_r[k]  <= fr_nxt[k];
      end
      cl4_r <= cl_nxt[0] || cl_nxt[1];
    end
    if (en5) begin
      fx5_r <= fr4_r[0];
      fz5_r <= fr4_r[1];
      up5_r <= upper;
      cl5_r <= cl4_r;
    end
    if (en6) begin
      da6_r <= da_nxt;
      db6_r <= db_nxt;
      h16_r <= h1_rd;
      fx6_r <= fx5_r;
      fz6_r <= fz5_r;
      cl6_r <= cl5_r;
    end
    if (en7) begin
      p17_r <= p1_nxt;
      p27_r <= p2_nxt;
      h17_r <= h16_r;
      cl7_r <= cl6_r;
    end
    if (en_out) begin
      out_h_r  <= height_nxt;
      out_cl_r <= cl7_r;
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.height  = out_h_r;
  assign out_if.clamped = out_cl_r;
endmodule

/* tb/tb_heightfield_triangle_interpolator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for heightfield_triangle_interpolator: vertex writes and
// point queries are predicted in-bench and each result is checked in order.
// Depends on hti_pkg, hti_if.sv and the RTL top level.
module tb_heightfield_triangle_interpolator;
  import hti_pkg::*;

  localparam int MAXC  = 16;
  localparam int SIDE  = MAXC + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       clamped;
  } height_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hti_in_if  in_if ();
  hti_out_if out_if ();
  hti_cfg_if cfg_if ();

  heightfield_triangle_interpolator dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirrored block state
  logic signed [HEIGHT_W-1:0] grid_mirror [DEPTH];
  logic [31:0] org_x, org_z, scl_x, scl_z;
  logic [4:0]  cells_reg;

  height_result_t pending_heights[$];
  bit failed = 1'b0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int rx_mode = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int rx_cyc = 0;
  int idle_cycles = 0;

  function automatic int eff_cells();
    int n;
    n = cells_reg;
    if (n == 0) n = 1;
    if (n > MAXC) n = MAXC;
    return n;
  endfunction

  function automatic void scale_coord(input logic [31:0] q, input logic [31:0] org,
                                      input logic [31:0] scl, input int n,
                                      output int idx, output longint fr, output bit cl);
    longint d;
    logic [63:0] mag, prod;
    d = longint'($signed(q)) - longint'($signed(org));
    mag = (d < 0) ? -d : d;
    prod = mag * {32'b0, scl};
    cl = 1'b0;
    if (d < 0 && prod != 0) begin
      idx = 0;
      fr = 0;
      cl = 1'b1;
    end else begin
      fr = prod[39:24];
      if (prod[63:40] > n) begin
        idx = n;
        cl = 1'b1;
      end else begin
        idx = prod[63:40];
      end
    end
  endfunction

  function automatic longint vtx(input int col, input int row);
    return longint'(grid_mirror[(row * SIDE + col) % DEPTH]);
  endfunction

  function automatic height_result_t interpolate(input logic [31:0] qx, input logic [31:0] qz);
    height_result_t r;
    int n, ix, iz, nx, nz;
    longint fx, fz, h1, h2, h3, h4, sum;
    bit cx, cz;
    n = eff_cells();
    scale_coord(qx, org_x, scl_x, n, ix, fx, cx);
    scale_coord(qz, org_z, scl_z, n, iz, fz, cz);
    nx = (ix + 1 <= n) ? ix + 1 : n;
    nz = (iz + 1 <= n) ? iz + 1 : n;
    h1 = vtx(ix, iz);
    h3 = vtx(nx, nz);
    if (fz > fx) begin
      h4 = vtx(ix, nz);
      sum = h1 * 65536 + (h4 - h1) * fz + (h3 - h4) * fx;
    end else begin
      h2 = vtx(nx, iz);
      sum = h1 * 65536 + (h3 - h2) * fz + (h2 - h1) * fx;
    end
    sum = (sum + 32768) >>> 16;
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    r.height = sum[HEIGHT_W-1:0];
    r.clamped = cx | cz;
    return r;
  endfunction

  task automatic send_request(input logic act, input logic [4:0] col, input logic [4:0] row,
                              input logic [23:0] hv, input logic [31:0] qx,
                              input logic [31:0] qz);
    int gap;
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.action = act;
    in_if.vertex_col = col;
    in_if.vertex_row = row;
    in_if.height_value = hv;
    in_if.query_x = qx;
    in_if.query_z = qz;
    do @(posedge clk); while (!in_if.ready);
    if (act == ACT_QUERY) pending_heights.push_back(interpolate(qx, qz));
    else if (col <= MAXC && row <= MAXC) grid_mirror[row * SIDE + col] = hv;
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      else begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  task automatic write_vertex(input int col, input int row, input logic [23:0] hv);
    send_request(ACT_WRITE, 5'(col), 5'(row), hv, $urandom, $urandom);
  endtask

  task automatic query_point(input logic [31:0] qx, input logic [31:0] qz);
    send_request(ACT_QUERY, 5'($urandom), 5'($urandom), 24'($urandom), qx, qz);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_ORIGIN_X:   org_x = val;
      CFG_ORIGIN_Z:   org_z = val;
      CFG_SCALE_X:    scl_x = val;
      CFG_SCALE_Z:    scl_z = val;
      CFG_CELL_COUNT: cells_reg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(input logic [31:0] ox, input logic [31:0] oz, input logic [31:0] sx,
                           input logic [31:0] sz, input logic [4:0] nc);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Z, sz);
    write_reg(CFG_CELL_COUNT, {27'b0, nc});
  endtask

  // mostly lands inside or just around the grid
  function automatic logic [31:0] near_coord(input logic [31:0] org, input logic [31:0] scl);
    longint t, d;
    if (scl == 0 || $urandom_range(0, 4) == 0) return $urandom;
    t = longint'($urandom_range(0, (eff_cells() + 2) * 65536)) - 65536;
    d = (t <<< 24) / longint'(scl);
    return org + d[31:0];
  endfunction

  task automatic random_query();
    query_point(near_coord(org_x, scl_x), near_coord(org_z, scl_z));
  endtask

  task automatic test_fill_grid();
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++) write_vertex(c, r, 24'($urandom));
    write_vertex(17, 3, 24'($urandom));
    write_vertex(2, 31, 24'($urandom));
    write_vertex(31, 31, 24'($urandom));
  endtask

  task automatic test_directed();
    configure(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 5'd16);
    write_vertex(0, 0, 24'h7FFFFF);
    write_vertex(1, 0, 24'h800000);
    write_vertex(0, 1, 24'h800000);
    write_vertex(1, 1, 24'h7FFFFF);
    query_point(32'h0, 32'h0);
    query_point(32'h0000_8000, 32'h0000_8000);
    query_point(32'h0000_4000, 32'h0000_C000);
    query_point(32'h0000_C000, 32'h0000_4000);
    query_point(32'hFFFF_FFFF, 32'h0000_8000);
    query_point(32'h0010_8000, 32'h0000_8000);
    query_point(32'h0010_0000, 32'h0010_0000);
    query_point(32'h7FFF_FFFF, 32'h8000_0000);
    query_point(32'h8000_0000, 32'h7FFF_FFFF);
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 5'd0);
    query_point(32'h7FFF_FFFF, 32'h8000_0000);
    query_point(32'h8000_0000, 32'h1234_5678);
    query_point(32'h8000_0001, 32'h7FFF_FFFF);
    configure(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd31);
    query_point(32'h0001_0000, 32'h0000_0001);
    query_point(32'hFFFF_0000, 32'h0000_1000);
    configure(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 5'd17);
    query_point(32'h0020_0000, 32'h000F_8000);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 9) == 0)
          write_vertex($urandom_range(17, 31), int'($urandom_range(0, 31)), 24'($urandom));
        else write_vertex($urandom_range(0, MAXC), $urandom_range(0, MAXC), 24'($urandom));
      end else begin
        random_query();
      end
    end
  endtask

  task automatic test_random();
    configure(32'h0, 32'h0, 32'd167772, 32'd167772, 5'd16);
    rx_mode = 1;
    random_phase(90);
    configure($urandom, $urandom, $urandom_range(32'h0040_0000, 32'h0400_0000),
              $urandom_range(32'h0040_0000, 32'h0400_0000), 5'($urandom_range(1, 16)));
    rx_mode = 2;
    random_phase(90);
    configure($urandom, $urandom, $urandom, $urandom, 5'($urandom));
    rx_mode = 0;
    no_gaps = 1'b1;
    random_phase(90);
    no_gaps = 1'b0;
    configure($urandom, $urandom, 32'h0100_0000, 32'h0080_0000, 5'd1);
    rx_mode = 1;
    random_phase(90);
    configure($urandom, $urandom, $urandom_range(32'h0100_0000, 32'h0800_0000),
              $urandom_range(32'h0100_0000, 32'h0800_0000), 5'd16);
    random_phase(90);
  endtask

  task automatic test_backpressure();
    configure(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000, 5'd8);
    hold_req = 1'b1;
    no_gaps = 1'b1;
    random_phase(80);
    no_gaps = 1'b0;
    rx_mode = 1;
  endtask

  // result side stall pattern and long hold-off
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ((rx_cyc % 11) < 6);
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    height_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result height=%h clamped=%b", $time, out_if.height,
                 out_if.clamped);
        failed = 1'b1;
      end else begin
        exp_r = pending_heights.pop_front();
        if (out_if.height !== exp_r.height) begin
          $display("%0t: height expected %h actual %h", $time, exp_r.height, out_if.height);
          failed = 1'b1;
        end
        if (out_if.clamped !== exp_r.clamped) begin
          $display("%0t: clamped expected %b actual %b", $time, exp_r.clamped,
                   out_if.clamped);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.action = ACT_WRITE;
    in_if.vertex_col = '0;
    in_if.vertex_row = '0;
    in_if.height_value = '0;
    in_if.query_x = '0;
    in_if.query_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ORIGIN_X;
    cfg_if.data = '0;
    out_if.ready = 1'b1;
    org_x = 32'h0;
    org_z = 32'h0;
    scl_x = 32'd167772;
    scl_z = 32'd167772;
    cells_reg = 5'd16;
    foreach (grid_mirror[i]) grid_mirror[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_fill_grid();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hti_pkg.sv
hw/rtl/hti_if.sv
hw/rtl/hti_ram.sv
hw/rtl/heightfield_triangle_interpolator.sv
tb/tb_heightfield_triangle_interpolator.sv
